[rtl/ddd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit display register package
// Field widths, request and register codes, shared types and the power of
// ten table used by the display register modules.
// ----------------------------------------------------------------------------
package ddd_pkg;

   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 27;
   localparam int INDEX_W     = 3;
   localparam int DIGIT_W     = 4;
   localparam int SHIFT_W     = 5;
   localparam int NUMBER_W    = 27;
   localparam int WORD_W      = 32;
   localparam int HELD_W      = 32;
   localparam int PROD_W      = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam int DEF_MAX_PIPES   = 8;
   localparam int DEF_DIGIT_LIMIT = 10;

   localparam logic [KIND_W-1:0] KIND_SET_NUMBER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_DIGIT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INCREMENT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DECREMENT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SHIFT      = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIPE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_COUNT = 2'd1;

   localparam logic [3:0] PIPE_COUNT_RESET = 4'd8;
   localparam logic [2:0] UNIT_COUNT_RESET = 3'd0;

   // Quotient by ten is (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x.
   localparam logic [HELD_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                RECIP_SHIFT = 35;

   typedef struct packed {
      logic capture;
      logic decode;
      logic cfg_write;
      logic split_mul;
      logic split_digit;
      logic shift_step;
      logic sum_init;
      logic sum_step;
      logic load_result;
   } ddd_cmd_type;

   typedef struct packed {
      logic need_split;
      logic is_shift;
      logic shift_done;
      logic split_last;
      logic sum_last;
   } ddd_status_type;

   function automatic logic [HELD_W-1:0] pow_ten(input logic [3:0] k);
      logic [HELD_W-1:0] r;
      case (k)
         4'd0:    r = 32'd1;
         4'd1:    r = 32'd10;
         4'd2:    r = 32'd100;
         4'd3:    r = 32'd1000;
         4'd4:    r = 32'd10000;
         4'd5:    r = 32'd100000;
         4'd6:    r = 32'd1000000;
         4'd7:    r = 32'd10000000;
         4'd8:    r = 32'd100000000;
         4'd9:    r = 32'd1000000000;
         default: r = 32'd1000000000;
      endcase
      return r;
   endfunction

endpackage

[rtl/ddd_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display request channel
// Valid/ready channel that carries one display request.
// ----------------------------------------------------------------------------
interface ddd_req_if;
   import ddd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [VALUE_W-1:0]        value;
   logic [INDEX_W-1:0]        pipe_index;
   logic [DIGIT_W-1:0]        digit;
   logic signed [SHIFT_W-1:0] shift_amount;

   modport source (output valid, kind, value, pipe_index, digit, shift_amount,
                   input ready);
   modport sink (input valid, kind, value, pipe_index, digit, shift_amount,
                 output ready);
endinterface

[rtl/ddd_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display response channel
// Valid/ready channel that carries the display state after a request.
// ----------------------------------------------------------------------------
interface ddd_rsp_if;
   import ddd_pkg::*;

   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] shown_number;
   logic [WORD_W-1:0]   digit_word;
   logic                ignored;

   modport source (output valid, shown_number, digit_word, ignored, input ready);
   modport sink (input valid, shown_number, digit_word, ignored, output ready);
endinterface

[rtl/ddd_csr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface ddd_csr_if;
   import ddd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/ddd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display register controller
// Sequences decode, digit split, shift steps and the digit-serial sum, and
// owns the request, configuration and response handshakes.
// ----------------------------------------------------------------------------
module ddd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ddd_pkg::ddd_status_type status,
   output ddd_pkg::ddd_cmd_type    cmd
);
   import ddd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SPLIT_MUL,
      S_SPLIT_DIG,
      S_SHIFT,
      S_SUM_INIT,
      S_SUM,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      cfg_pass_ff, cfg_pass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cfg_pass_in  = cfg_pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               cfg_pass_in   = 1'b1;
               state_in      = S_SUM_INIT;
            end else if (req_valid) begin
               cmd.capture = 1'b1;
               cfg_pass_in = 1'b0;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (status.need_split) begin
               state_in = S_SPLIT_MUL;
            end else if (status.is_shift) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_SUM_INIT;
            end
         end
         S_SPLIT_MUL: begin
            cmd.split_mul = 1'b1;
            state_in      = S_SPLIT_DIG;
         end
         S_SPLIT_DIG: begin
            cmd.split_digit = 1'b1;
            state_in        = status.split_last ? S_SUM_INIT : S_SPLIT_MUL;
         end
         S_SHIFT: begin
            if (status.shift_done) begin
               state_in = S_SUM_INIT;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_SUM_INIT: begin
            cmd.sum_init = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = cfg_pass_ff ? S_IDLE : S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_pass_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_pass_ff  <= cfg_pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_req_to_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("request accept did not start decode");

   a_csr_to_sum: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (state_ff == S_SUM_INIT && cfg_pass_ff))
      else $error("configuration write did not start a silent sum pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      !((req_valid && req_ready) && (csr_valid && csr_ready)))
      else $error("request and configuration write taken together");
`endif

endmodule

[rtl/ddd_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display register datapath
// Holds the pipe digits, the binary number, the configuration and the
// response registers, with the divide-by-ten split and the digit-serial sum.
// ----------------------------------------------------------------------------
module ddd_dpath #(
   parameter int MAX_PIPES   = ddd_pkg::DEF_MAX_PIPES,
   parameter int DIGIT_LIMIT = ddd_pkg::DEF_DIGIT_LIMIT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ddd_pkg::ddd_cmd_type                cmd,
   output ddd_pkg::ddd_status_type             status,
   input  logic [ddd_pkg::KIND_W-1:0]          req_kind,
   input  logic [ddd_pkg::VALUE_W-1:0]         req_value,
   input  logic [ddd_pkg::INDEX_W-1:0]         req_pipe_index,
   input  logic [ddd_pkg::DIGIT_W-1:0]         req_digit,
   input  logic signed [ddd_pkg::SHIFT_W-1:0]  req_shift_amount,
   input  logic [ddd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ddd_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [ddd_pkg::NUMBER_W-1:0]        rsp_shown_number,
   output logic [ddd_pkg::WORD_W-1:0]          rsp_digit_word,
   output logic                                rsp_ignored
);
   import ddd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PIPES + 1);
   localparam int IDX_W = (MAX_PIPES > 1) ? $clog2(MAX_PIPES) : 1;
   localparam int WORD_PIPES = WORD_W / DIGIT_W;

   logic [3:0]                pipe_count_ff;
   logic [2:0]                unit_count_ff;
   logic [DIGIT_W-1:0]        digits_ff [MAX_PIPES];
   logic [DIGIT_W-1:0]        digits_in [MAX_PIPES];
   logic [HELD_W-1:0]         held_ff;
   logic [KIND_W-1:0]         kind_ff;
   logic [VALUE_W-1:0]        value_ff;
   logic [INDEX_W-1:0]        index_ff;
   logic [DIGIT_W-1:0]        digit_ff;
   logic signed [SHIFT_W-1:0] shift_ff;
   logic [HELD_W-1:0]         work_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [IDX_W-1:0]          cnt_ff;
   logic [CNT_W-1:0]          steps_ff;
   logic                      left_ff;
   logic                      ignored_ff;
   logic [NUMBER_W-1:0]       rsp_number_ff;
   logic [WORD_W-1:0]         rsp_word_ff;
   logic                      rsp_ignored_ff;

   logic [CNT_W-1:0]          pipes;
   logic [CNT_W-1:0]          pipes_top;
   logic [IDX_W-1:0]          units;
   logic [CNT_W-1:0]          number_digits;
   logic [HELD_W-1:0]         largest;
   logic [HELD_W-1:0]         temp_num;
   logic                      number_kind;
   logic                      ignore_now;
   logic signed [31:0]        shift_ext;
   logic [31:0]               shift_mag;
   logic [31:0]               shift_clamp;
   logic [HELD_W-1:0]         quotient;
   logic [HELD_W-1:0]         quotient_ten;
   logic [DIGIT_W-1:0]        remainder;
   logic [MAX_PIPES-1:0]      lane_num;
   logic [DIGIT_W-1:0]        lower_nb [MAX_PIPES];
   logic [DIGIT_W-1:0]        upper_nb [MAX_PIPES];
   logic [WORD_W-1:0]         word_next;

   always_comb begin
      if (pipe_count_ff == 4'd0) begin
         pipes = CNT_W'(1);
      end else if (32'(pipe_count_ff) > MAX_PIPES) begin
         pipes = CNT_W'(MAX_PIPES);
      end else begin
         pipes = CNT_W'(pipe_count_ff);
      end
      pipes_top = pipes - CNT_W'(1);
      if (32'(unit_count_ff) > 32'(pipes_top)) begin
         units = IDX_W'(pipes_top);
      end else begin
         units = IDX_W'(unit_count_ff);
      end
      number_digits = pipes - CNT_W'(units);
      largest       = pow_ten(4'(number_digits)) - 32'd1;
   end

   always_comb begin
      number_kind = (kind_ff == KIND_SET_NUMBER) || (kind_ff == KIND_INCREMENT) ||
                    (kind_ff == KIND_DECREMENT);
      case (kind_ff)
         KIND_INCREMENT: temp_num = (held_ff < largest) ? held_ff + 32'd1 : 32'd0;
         KIND_DECREMENT: temp_num = (held_ff > 32'd0) ? held_ff - 32'd1 : largest;
         default:        temp_num = 32'(value_ff);
      endcase
      case (kind_ff)
         KIND_SET_NUMBER: ignore_now = (temp_num > largest);
         KIND_INCREMENT:  ignore_now = (temp_num > largest);
         KIND_DECREMENT:  ignore_now = (temp_num > largest);
         KIND_SET_DIGIT:  ignore_now = (32'(index_ff) >= 32'(pipes)) ||
                                       (32'(digit_ff) >= DIGIT_LIMIT);
         KIND_SHIFT:      ignore_now = 1'b0;
         default:         ignore_now = 1'b1;
      endcase
      shift_ext   = {{(32 - SHIFT_W){shift_ff[SHIFT_W-1]}}, shift_ff};
      shift_mag   = shift_ext[31] ? 32'(-shift_ext) : 32'(shift_ext);
      shift_clamp = (shift_mag > MAX_PIPES) ? 32'(MAX_PIPES) : shift_mag;
   end

   assign quotient     = HELD_W'(prod_ff >> RECIP_SHIFT);
   assign quotient_ten = (quotient << 3) + (quotient << 1);
   assign remainder    = DIGIT_W'(work_ff - quotient_ten);

   for (genvar g = 0; g < MAX_PIPES; g++) begin : g_lane
      assign lane_num[g] = (32'(g) >= 32'(units)) && (32'(g) < 32'(pipes));
      if (g > 0) begin : g_low
         assign lower_nb[g] = lane_num[g-1] ? digits_ff[g-1] : '0;
      end else begin : g_low0
         assign lower_nb[g] = '0;
      end
      if (g < MAX_PIPES - 1) begin : g_up
         assign upper_nb[g] = lane_num[g+1] ? digits_ff[g+1] : '0;
      end else begin : g_up0
         assign upper_nb[g] = '0;
      end
   end

   for (genvar w = 0; w < WORD_PIPES; w++) begin : g_word
      if (w < MAX_PIPES) begin : g_used
         assign word_next[w*DIGIT_W +: DIGIT_W] =
            (32'(w) < 32'(pipes)) ? digits_ff[w] : '0;
      end else begin : g_none
         assign word_next[w*DIGIT_W +: DIGIT_W] = '0;
      end
   end

   always_comb begin
      digits_in = digits_ff;
      if (cmd.decode && (kind_ff == KIND_SET_DIGIT) && !ignore_now) begin
         digits_in[IDX_W'(index_ff)] = digit_ff;
      end
      if (cmd.split_digit && (32'(remainder) < DIGIT_LIMIT)) begin
         digits_in[cnt_ff] = remainder;
      end
      if (cmd.shift_step) begin
         for (int i = 0; i < MAX_PIPES; i++) begin
            if (lane_num[i]) begin
               digits_in[i] = left_ff ? lower_nb[i] : upper_nb[i];
            end
         end
      end
   end

   assign status.need_split = cmd.decode && number_kind && !ignore_now;
   assign status.is_shift   = (kind_ff == KIND_SHIFT);
   assign status.shift_done = (steps_ff == '0);
   assign status.split_last = (32'(cnt_ff) == 32'(pipes_top));
   assign status.sum_last   = (cnt_ff == units);

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_count_ff <= PIPE_COUNT_RESET;
         unit_count_ff <= UNIT_COUNT_RESET;
         held_ff       <= '0;
         for (int i = 0; i < MAX_PIPES; i++) begin
            digits_ff[i] <= '0;
         end
      end else begin
         digits_ff <= digits_in;
         if (cmd.cfg_write) begin
            if (csr_index == CSR_PIPE_COUNT) begin
               pipe_count_ff <= csr_data[3:0];
            end else if (csr_index == CSR_UNIT_COUNT) begin
               unit_count_ff <= csr_data[2:0];
            end
         end
         if (cmd.sum_init) begin
            held_ff <= '0;
         end else if (cmd.sum_step) begin
            held_ff <= (held_ff << 3) + (held_ff << 1) + 32'(digits_ff[cnt_ff]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
         index_ff <= req_pipe_index;
         digit_ff <= req_digit;
         shift_ff <= req_shift_amount;
      end
      if (cmd.decode) begin
         ignored_ff <= ignore_now;
         work_ff    <= temp_num;
         cnt_ff     <= units;
         steps_ff   <= CNT_W'(shift_clamp);
         left_ff    <= !shift_ext[31];
      end
      if (cmd.split_mul) begin
         prod_ff <= PROD_W'(work_ff) * PROD_W'(RECIP_TEN);
      end
      if (cmd.split_digit) begin
         work_ff <= quotient;
         if (!status.split_last) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
         end
      end
      if (cmd.shift_step) begin
         steps_ff <= steps_ff - CNT_W'(1);
      end
      if (cmd.sum_init) begin
         cnt_ff <= IDX_W'(pipes_top);
      end else if (cmd.sum_step && !status.sum_last) begin
         cnt_ff <= cnt_ff - IDX_W'(1);
      end
      if (cmd.load_result) begin
         rsp_number_ff  <= held_ff[NUMBER_W-1:0];
         rsp_word_ff    <= word_next;
         rsp_ignored_ff <= ignored_ff;
      end
   end

   assign rsp_shown_number = rsp_number_ff;
   assign rsp_digit_word   = rsp_word_ff;
   assign rsp_ignored      = rsp_ignored_ff;

`ifndef SYNTH
   a_split_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.split_digit |-> (remainder < 4'd10))
      else $error("divide by ten left a remainder of ten or more");

   a_split_in_number: assert property (@(posedge clock) disable iff (reset)
      cmd.split_digit |-> (32'(cnt_ff) >= 32'(units) && 32'(cnt_ff) < 32'(pipes)))
      else $error("split wrote outside the number pipes");

   a_sum_in_number: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_step |-> (32'(cnt_ff) >= 32'(units) && 32'(cnt_ff) < 32'(pipes)))
      else $error("sum read outside the number pipes");
`endif

endmodule

[rtl/decimal_digit_display_register.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit display register
// Keeps one decimal digit per display pipe and the binary number they show.
// ----------------------------------------------------------------------------
// A request on req_ch sets the number, sets one digit, increments, decrements
// or shifts the number digits. Every request yields one response on rsp_ch
// with the number held, all digits four bits per pipe, and an ignored flag.
// Registers pipe_count (index 0) and unit_count (index 1) are written on
// csr_ch while no request is in flight; each write starts a silent resum
// of the number digits, during which no request is taken.
// A set number, increment or decrement that is carried out goes through
// decode, a multiply by reciprocal and a digit step of the divide by ten
// for each number digit, then the serial sum and the response load. A shift
// by s moves the number digits by min(|s|, MAX_PIPES) pipes, one per step,
// leaves the shift loop and then runs the serial sum. Everything else,
// including a set number that is ignored, goes from decode to the sum. One request
// is worked on at a time; the next is taken as soon as the block is idle.
// Reset clears all digits and the number, selects 8 pipes and no unit pipes.
// A stalled response holds in the output register; a following request is
// still accepted and processed, and waits for that register to free up.
// ----------------------------------------------------------------------------
module decimal_digit_display_register #(
   parameter int MAX_PIPES   = ddd_pkg::DEF_MAX_PIPES,
   parameter int DIGIT_LIMIT = ddd_pkg::DEF_DIGIT_LIMIT
) (
   input logic     clock,
   input logic     reset,
   ddd_req_if.sink   req_ch,
   ddd_rsp_if.source rsp_ch,
   ddd_csr_if.sink   csr_ch
);
   import ddd_pkg::*;

   ddd_cmd_type    cmd;
   ddd_status_type status;

   ddd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddd_dpath #(
      .MAX_PIPES   (MAX_PIPES),
      .DIGIT_LIMIT (DIGIT_LIMIT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_ch.kind),
      .req_value        (req_ch.value),
      .req_pipe_index   (req_ch.pipe_index),
      .req_digit        (req_ch.digit),
      .req_shift_amount (req_ch.shift_amount),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_shown_number (rsp_ch.shown_number),
      .rsp_digit_word   (rsp_ch.digit_word),
      .rsp_ignored      (rsp_ch.ignored)
   );

endmodule

[verif/decimal_digit_display_register_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit display register testbench
// Drives display requests and register writes through the valid/ready
// channels with random idle gaps on both sides. A behavioral copy of the
// digit store predicts each response that a directed row does not give,
// and each response is checked field by field. A short directed list comes
// first, then random requests over several pipe and unit pipe settings.
// ----------------------------------------------------------------------------
module decimal_digit_display_register_tb;
   import ddd_pkg::*;

   localparam int MAX_PIPES   = DEF_MAX_PIPES;
   localparam int DIGIT_LIMIT = DEF_DIGIT_LIMIT;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 50;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic [VALUE_W-1:0]        value;
      logic [INDEX_W-1:0]        pipe_index;
      logic [DIGIT_W-1:0]        digit;
      logic signed [SHIFT_W-1:0] shift_amount;
   } display_request_type;

   typedef struct {
      logic [NUMBER_W-1:0] shown_number;
      logic [WORD_W-1:0]   digit_word;
      logic                ignored;
   } display_state_type;

   typedef struct {
      display_request_type req;
      bit                  typed;
      display_state_type   want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic take_ready = 1'b0;

   ddd_req_if req_ch ();
   ddd_rsp_if rsp_ch ();
   ddd_csr_if csr_ch ();

   assign rsp_ch.ready = take_ready;

   decimal_digit_display_register dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   logic [DIGIT_W-1:0] model_digits [MAX_PIPES];
   logic [HELD_W-1:0]  model_number;
   logic [3:0]         model_pipe_count;
   logic [2:0]         model_unit_count;

   display_state_type awaited_displays [$];
   directed_row_type  directed_rows [$];
   bit                steady_flow = 1'b0;
   int unsigned       stall_left = 0;
   int                mismatch_count = 0;
   int                requests_sent = 0;
   int                responses_seen = 0;
   int                ignored_requests = 0;
   int                register_writes = 0;

   function automatic int active_pipes();
      int p;
      p = model_pipe_count;
      if (p < 1) p = 1;
      if (p > MAX_PIPES) p = MAX_PIPES;
      return p;
   endfunction

   function automatic int unit_pipes();
      int u;
      u = model_unit_count;
      if (u > active_pipes() - 1) u = active_pipes() - 1;
      return u;
   endfunction

   function automatic logic [HELD_W-1:0] ten_to(int k);
      logic [HELD_W-1:0] r;
      r = 32'd1;
      repeat (k) r = r * 32'd10;
      return r;
   endfunction

   function automatic logic [HELD_W-1:0] top_value();
      return ten_to(active_pipes() - unit_pipes()) - 32'd1;
   endfunction

   function automatic void store_digit(int i, logic [HELD_W-1:0] d);
      logic [HELD_W-1:0] w;
      if (d >= DIGIT_LIMIT || i >= MAX_PIPES) return;
      if (i >= unit_pipes()) begin
         w = ten_to(i - unit_pipes());
         model_number = model_number - {28'd0, model_digits[i]} * w + d * w;
      end
      model_digits[i] = d[DIGIT_W-1:0];
   endfunction

   function automatic bit split_number(logic [HELD_W-1:0] num);
      int i;
      i = unit_pipes();
      if (num > top_value()) return 1'b0;
      do begin
         store_digit(i, num % 32'd10);
         num = num / 32'd10;
         i++;
      end while (i < active_pipes());
      return 1'b1;
   endfunction

   function automatic void resum_number();
      model_number = '0;
      for (int i = unit_pipes(); i < active_pipes(); i++)
         model_number = model_number + {28'd0, model_digits[i]} * ten_to(i - unit_pipes());
   endfunction

   // Walking away from the destination keeps every source digit unwritten
   // until it has been read, so the loop order matters.
   function automatic void shift_number(int n);
      int lo;
      int hi;
      int src;
      logic [HELD_W-1:0] d;
      lo = unit_pipes();
      hi = active_pipes();
      if (n > MAX_PIPES) n = MAX_PIPES;
      if (n < -MAX_PIPES) n = -MAX_PIPES;
      if (n >= 0) begin
         for (int i = hi - 1; i >= lo; i--) begin
            src = i - n;
            d = (src >= lo && src < hi) ? {28'd0, model_digits[src]} : 32'd0;
            store_digit(i, d);
         end
      end else begin
         for (int i = lo; i < hi; i++) begin
            src = i - n;
            d = (src >= lo && src < hi) ? {28'd0, model_digits[src]} : 32'd0;
            store_digit(i, d);
         end
      end
   endfunction

   function automatic display_state_type apply_request(display_request_type r);
      display_state_type s;
      logic [HELD_W-1:0] t;
      logic ign;
      ign = 1'b0;
      case (r.kind)
         KIND_SET_NUMBER: ign = !split_number({5'd0, r.value});
         KIND_SET_DIGIT: begin
            if (r.pipe_index >= active_pipes() || r.digit >= DIGIT_LIMIT) ign = 1'b1;
            else store_digit(r.pipe_index, {28'd0, r.digit});
         end
         KIND_INCREMENT: begin
            t = (model_number < top_value()) ? model_number + 32'd1 : 32'd0;
            ign = !split_number(t);
         end
         KIND_DECREMENT: begin
            t = (model_number > 32'd0) ? model_number - 32'd1 : top_value();
            ign = !split_number(t);
         end
         KIND_SHIFT: shift_number(r.shift_amount);
         default: ign = 1'b1;
      endcase
      s.digit_word = '0;
      for (int i = 0; i < active_pipes(); i++) s.digit_word[4*i +: 4] = model_digits[i];
      s.shown_number = model_number[NUMBER_W-1:0];
      s.ignored = ign;
      return s;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_PIPE_COUNT) model_pipe_count = data[3:0];
      else if (idx == CSR_UNIT_COUNT) model_unit_count = data[2:0];
      else return;
      resum_number();
   endfunction

   function automatic directed_row_type make_row(logic [KIND_W-1:0] kind,
                                                 logic [VALUE_W-1:0] value,
                                                 logic [INDEX_W-1:0] pipe_index,
                                                 logic [DIGIT_W-1:0] digit,
                                                 logic signed [SHIFT_W-1:0] shift_amount,
                                                 bit typed,
                                                 logic [NUMBER_W-1:0] number,
                                                 logic [WORD_W-1:0] word,
                                                 logic ignored);
      directed_row_type row;
      row.req.kind = kind;
      row.req.value = value;
      row.req.pipe_index = pipe_index;
      row.req.digit = digit;
      row.req.shift_amount = shift_amount;
      row.typed = typed;
      row.want.shown_number = number;
      row.want.digit_word = word;
      row.want.ignored = ignored;
      return row;
   endfunction

   function automatic display_request_type random_request();
      display_request_type r;
      logic [HELD_W-1:0] top;
      int roll;
      top = top_value();
      r.kind = KIND_SET_NUMBER;
      r.value = VALUE_W'($urandom);
      r.pipe_index = INDEX_W'($urandom);
      r.digit = DIGIT_W'($urandom);
      r.shift_amount = SHIFT_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 25) begin
         case ($urandom_range(9))
            0: r.value = top[VALUE_W-1:0];
            1: r.value = VALUE_W'(top + 32'd1);
            2: r.value = '0;
            3: ;
            default: r.value = VALUE_W'($urandom_range(top, 0));
         endcase
      end else if (roll < 50) begin
         r.kind = KIND_SET_DIGIT;
         if ($urandom_range(99) < 85) r.digit = DIGIT_W'($urandom_range(9, 0));
         else r.digit = DIGIT_W'($urandom_range(15, 10));
      end else if (roll < 65) begin
         r.kind = KIND_INCREMENT;
      end else if (roll < 80) begin
         r.kind = KIND_DECREMENT;
      end else if (roll < 95) begin
         r.kind = KIND_SHIFT;
         if ($urandom_range(99) < 80) r.shift_amount = SHIFT_W'($urandom_range(16, 0) - 8);
      end else begin
         r.kind = KIND_W'($urandom_range(KIND_SPARE_C, KIND_SPARE_A));
      end
      return r;
   endfunction

   function automatic int unsigned idle_cycles();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic send_request(display_request_type r, bit typed,
                               display_state_type typed_want);
      int unsigned gap;
      display_state_type want;
      gap = idle_cycles();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= r.kind;
      req_ch.value <= r.value;
      req_ch.pipe_index <= r.pipe_index;
      req_ch.digit <= r.digit;
      req_ch.shift_amount <= r.shift_amount;
      do @(posedge clock); while (!req_ch.ready);
      want = apply_request(r);
      if (typed) want = typed_want;
      if (want.ignored) ignored_requests++;
      awaited_displays.push_back(want);
      requests_sent++;
   endtask

   task automatic write_settings(logic [CSR_DATA_W-1:0] pipe_data,
                                 logic [CSR_DATA_W-1:0] unit_data);
      logic [CSR_INDEX_W-1:0] idx [2];
      logic [CSR_DATA_W-1:0]  data [2];
      if ($urandom_range(1) == 0) begin
         idx[0] = CSR_PIPE_COUNT; data[0] = pipe_data;
         idx[1] = CSR_UNIT_COUNT; data[1] = unit_data;
      end else begin
         idx[0] = CSR_UNIT_COUNT; data[0] = unit_data;
         idx[1] = CSR_PIPE_COUNT; data[1] = pipe_data;
      end
      for (int k = 0; k < 2; k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[k];
         csr_ch.data <= data[k];
         do @(posedge clock); while (!csr_ch.ready);
         apply_register(idx[k], data[k]);
         register_writes++;
      end
      csr_ch.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         take_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         take_ready <= 1'b1;
         stall_left <= ($urandom_range(3) == 0) ? idle_cycles() : 0;
      end
   end

   always @(posedge clock) begin
      display_state_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (awaited_displays.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch %0d: response with no request outstanding", mismatch_count);
         end else begin
            want = awaited_displays.pop_front();
            if (rsp_ch.shown_number !== want.shown_number ||
                rsp_ch.digit_word !== want.digit_word || rsp_ch.ignored !== want.ignored) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch %0d: expected number %0d word %h ignored %0b,",
                            " got number %0d word %h ignored %0b"},
                           mismatch_count, want.shown_number, want.digit_word, want.ignored,
                           rsp_ch.shown_number, rsp_ch.digit_word, rsp_ch.ignored);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [CSR_DATA_W-1:0] phase_pipes [PHASES];
      logic [CSR_DATA_W-1:0] phase_units [PHASES];
      display_state_type none;

      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_SET_NUMBER;
      req_ch.value <= '0;
      req_ch.pipe_index <= '0;
      req_ch.digit <= '0;
      req_ch.shift_amount <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_PIPE_COUNT;
      csr_ch.data <= '0;

      for (int i = 0; i < MAX_PIPES; i++) model_digits[i] = '0;
      model_number = '0;
      model_pipe_count = PIPE_COUNT_RESET;
      model_unit_count = UNIT_COUNT_RESET;
      none.shown_number = '0;
      none.digit_word = '0;
      none.ignored = 1'b0;

      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'd0, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd0, 32'h0000_0000, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'd99999999, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd99999999, 32'h9999_9999, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'd100000000, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd99999999, 32'h9999_9999, 1'b1));
      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'h7FF_FFFF, 3'd7, 4'd15, -5'sd1,
                                       1'b1, 27'd99999999, 32'h9999_9999, 1'b1));
      directed_rows.push_back(make_row(KIND_INCREMENT, 27'd0, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd0, 32'h0000_0000, 1'b0));
      directed_rows.push_back(make_row(KIND_DECREMENT, 27'd0, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd99999999, 32'h9999_9999, 1'b0));
      directed_rows.push_back(make_row(KIND_DECREMENT, 27'd0, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd99999998, 32'h9999_9998, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_DIGIT, 27'd0, 3'd0, 4'd15, 5'sd0,
                                       1'b1, 27'd99999998, 32'h9999_9998, 1'b1));
      directed_rows.push_back(make_row(KIND_SET_DIGIT, 27'd0, 3'd7, 4'd10, 5'sd0,
                                       1'b1, 27'd99999998, 32'h9999_9998, 1'b1));
      directed_rows.push_back(make_row(KIND_SET_DIGIT, 27'd0, 3'd7, 4'd0, 5'sd0,
                                       1'b1, 27'd9999998, 32'h0999_9998, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'd12345678, 3'd0, 4'd0, 5'sd0,
                                       1'b1, 27'd12345678, 32'h1234_5678, 1'b0));
      directed_rows.push_back(make_row(KIND_SHIFT, 27'd0, 3'd0, 4'd0, 5'sd1,
                                       1'b1, 27'd23456780, 32'h2345_6780, 1'b0));
      directed_rows.push_back(make_row(KIND_SHIFT, 27'd0, 3'd0, 4'd0, -5'sd1,
                                       1'b1, 27'd2345678, 32'h0234_5678, 1'b0));
      directed_rows.push_back(make_row(KIND_SHIFT, 27'd0, 3'd0, 4'd0, 5'sd15,
                                       1'b1, 27'd0, 32'h0000_0000, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'd87654321, 3'd0, 4'd0, 5'sd0,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SHIFT, 27'd0, 3'd0, 4'd0, 5'sd0,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SHIFT, 27'd0, 3'd0, 4'd0, 5'sd8,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_NUMBER, 27'd87654321, 3'd0, 4'd0, 5'sd0,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SHIFT, 27'd0, 3'd0, 4'd0, -5'sd16,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_DIGIT, 27'd0, 3'd7, 4'd9, 5'sd0,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SET_DIGIT, 27'd0, 3'd0, 4'd9, 5'sd0,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SPARE_A, 27'd5, 3'd1, 4'd1, 5'sd1,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SPARE_B, 27'd6, 3'd2, 4'd2, 5'sd2,
                                       1'b0, '0, '0, 1'b0));
      directed_rows.push_back(make_row(KIND_SPARE_C, 27'd7, 3'd3, 4'd3, 5'sd3,
                                       1'b0, '0, '0, 1'b0));

      phase_pipes[0] = 4'd0;  phase_units[0] = 4'd0;
      phase_pipes[1] = 4'd8;  phase_units[1] = 4'd7;
      phase_pipes[2] = 4'd15; phase_units[2] = 4'd15;
      phase_pipes[3] = 4'd8;  phase_units[3] = 4'd0;
      phase_pipes[4] = 4'd3;  phase_units[4] = 4'd6;
      phase_pipes[5] = 4'd5;  phase_units[5] = 4'd2;
      phase_pipes[6] = 4'd1;  phase_units[6] = 4'd3;
      for (int p = 7; p < PHASES; p++) begin
         phase_pipes[p] = CSR_DATA_W'($urandom);
         phase_units[p] = CSR_DATA_W'($urandom);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < PHASES; p++) begin
         req_ch.valid <= 1'b0;
         while (awaited_displays.size() != 0) @(posedge clock);
         steady_flow = (p % 3 == 2);
         write_settings(phase_pipes[p], phase_units[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), 1'b0, none);
      end
      req_ch.valid <= 1'b0;
      steady_flow = 1'b0;

      while (awaited_displays.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d display requests (%0d rejected) across %0d register writes.",
               requests_sent, ignored_requests, register_writes);
      $display("Checked %0d responses against the predicted digits and number.",
               responses_seen);
      if (mismatch_count == 0 && awaited_displays.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/ddd_pkg.sv
rtl/ddd_req_if.sv
rtl/ddd_rsp_if.sv
rtl/ddd_csr_if.sv
rtl/ddd_ctrl.sv
rtl/ddd_dpath.sv
rtl/decimal_digit_display_register.sv
verif/decimal_digit_display_register_tb.sv
